// ===== hdl/alias_smp_pkg.sv =====
// alias_smp_pkg: shared widths, generator constants, opcodes and the
// controller-to-datapath command bundle of the alias method sampler
// no dependencies
`default_nettype none

package alias_smp_pkg;

    // table geometry
    localparam int MAX_CATEGORIES = 1024;
    localparam int IDX_W          = 10;
    localparam int SIZE_W         = 11;
    localparam int THR_W          = 33;

    // generator
    localparam int LCG_W    = 48;
    localparam int DRAW_W   = 32;
    localparam int HALF_W   = 24;
    localparam int MUL_W    = HALF_W + DRAW_W;
    localparam logic [DRAW_W-1:0] LCG_MULT_LO = 32'hDEEC_E66D;
    localparam logic [LCG_W-1:0]  LCG_INC     = 48'h0000_0000_000B;
    localparam logic [LCG_W-1:0]  LCG_RESET   = 48'h0000_0F0F_0F0F;

    // opcodes
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OP_W-1:0] OP_RESEED = 2'd2;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1;

    typedef struct packed {
        logic load_seed;
        logic wr_entry;
        logic mul_lo;
        logic mul_hi;
        logic add_step;
        logic slot_en;
        logic mem_rd;
        logic decide;
    } t_ctrl_cmd;

endpackage

`default_nettype wire

// ===== hdl/alias_method_sampler_top.sv =====
// alias_method_sampler_top: alias method sampler with apb table-size register
// depends on alias_smp_pkg, alias_smp_ctrl, alias_smp_dp
//
// channel   | direction | handshake                      | payload
// ----------+-----------+--------------------------------+--------------------------------
// command   | in        | start high while busy low      | opcode, entry_*, seed_value
// result    | out       | o_sample_valid, one cycle      | sample_index, from_alias
// config    | in/out    | psel/penable/pwrite, pready=1  | table_size at byte address 0
//
// table write and reseed transactions take effect at the accepting edge
// a sample transaction keeps busy high through two generator steps (low and high
//   partial products on one 24x32 multiplier, then the add), then the keep/alias
//   decision; the result strobe comes the cycle after
// a new transaction can be accepted in the cycle the result strobe is shown
// synchronous active-low reset: generator state 0x0F0F0F0F, table_size 1, tables undefined
// the result receiver cannot stall; results are dropped by nobody but a deaf receiver
`default_nettype none

module alias_method_sampler_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // command transactions
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [alias_smp_pkg::OP_W-1:0]      i_opcode,
    input  wire logic [alias_smp_pkg::IDX_W-1:0]     i_entry_index,
    input  wire logic [alias_smp_pkg::THR_W-1:0]     i_entry_threshold,
    input  wire logic [alias_smp_pkg::IDX_W-1:0]     i_entry_alias,
    input  wire logic [alias_smp_pkg::LCG_W-1:0]     i_seed_value,
    // results
    output logic                                     o_sample_valid,
    output logic [alias_smp_pkg::IDX_W-1:0]          o_sample_index,
    output logic                                     o_from_alias,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [alias_smp_pkg::APB_AW-1:0]    paddr,
    input  wire logic [alias_smp_pkg::APB_DW-1:0]    pwdata,
    output logic [alias_smp_pkg::APB_DW-1:0]         prdata,
    output logic                                     pready
);

    logic [alias_smp_pkg::SIZE_W-1:0] r_table_size;
    logic                             cfg_wr;
    logic                             size_sel;
    alias_smp_pkg::t_ctrl_cmd         cmd;

    // one register at word 0; word 1 decodes to nothing
    assign pready   = 1'b1;
    assign size_sel = (paddr[2] == 1'b0);
    assign cfg_wr   = psel && penable && pwrite && pready && size_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= alias_smp_pkg::SIZE_RESET;
        end else if (cfg_wr) begin
            r_table_size <= pwdata[alias_smp_pkg::SIZE_W-1:0];
        end
    end

    // readback of table_size, zero elsewhere
    always_comb begin
        prdata = '0;
        if (size_sel) begin
            prdata[alias_smp_pkg::SIZE_W-1:0] = r_table_size;
        end
    end

    // sequencer: accepts transactions, steps the generator, times the table read
    alias_smp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    // datapath: generator, slot multiply, entry memory, decision and result register
    alias_smp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_table_size      (r_table_size),
        .i_entry_index     (i_entry_index),
        .i_entry_threshold (i_entry_threshold),
        .i_entry_alias     (i_entry_alias),
        .i_seed_value      (i_seed_value),
        .o_sample_valid    (o_sample_valid),
        .o_sample_index    (o_sample_index),
        .o_from_alias      (o_from_alias)
    );

endmodule

`default_nettype wire

// ===== hdl/alias_smp_ctrl.sv =====
// alias_smp_ctrl: sequencer for table writes, reseeds and sample draws
// depends on alias_smp_pkg
`default_nettype none

module alias_smp_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic [alias_smp_pkg::OP_W-1:0] i_opcode,
    output logic                               busy,
    output alias_smp_pkg::t_ctrl_cmd           o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_LO = 3'd1;
    localparam logic [2:0] ST_MUL_HI = 3'd2;
    localparam logic [2:0] ST_ADD    = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_second;
    logic       n_second;
    logic       accept;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_opcode == alias_smp_pkg::OP_SAMPLE) begin
                    n_state  = ST_MUL_LO;
                    n_second = 1'b0;
                end
            end
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_ADD;
            ST_ADD: begin
                if (r_second) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_state  = ST_MUL_LO;
                    n_second = 1'b1;
                end
            end
            ST_DECIDE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    always_comb begin
        o_cmd.load_seed = accept && (i_opcode == alias_smp_pkg::OP_RESEED);
        o_cmd.wr_entry  = accept && (i_opcode == alias_smp_pkg::OP_WRITE);
        o_cmd.mul_lo    = (r_state == ST_MUL_LO);
        o_cmd.mul_hi    = (r_state == ST_MUL_HI);
        o_cmd.add_step  = (r_state == ST_ADD);
        // slot pick and table read overlap the second generator step
        o_cmd.slot_en   = (r_state == ST_MUL_LO) && r_second;
        o_cmd.mem_rd    = (r_state == ST_MUL_HI) && r_second;
        o_cmd.decide    = (r_state == ST_DECIDE);
    end

    a_sample_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == alias_smp_pkg::OP_SAMPLE) |=> (r_state == ST_MUL_LO && !r_second))
        else $error("sample transaction did not start the first generator step");

    a_second_step_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD && !r_second) |=> (r_state == ST_MUL_LO && r_second))
        else $error("second generator step not started after the first");

    a_decide_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) |=> (r_state == ST_IDLE))
        else $error("controller did not return to idle after the decision");

    a_no_write_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wr_entry || o_cmd.load_seed) |-> (r_state == ST_IDLE && !o_cmd.add_step))
        else $error("table write or reseed issued during a sample");

endmodule

`default_nettype wire

// ===== hdl/alias_smp_dp.sv =====
// alias_smp_dp: generator, slot pick, threshold/alias table and result register
// depends on alias_smp_pkg; driven by alias_smp_ctrl commands
`default_nettype none

module alias_smp_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire alias_smp_pkg::t_ctrl_cmd          i_cmd,
    input  wire logic [alias_smp_pkg::SIZE_W-1:0]  i_table_size,
    input  wire logic [alias_smp_pkg::IDX_W-1:0]   i_entry_index,
    input  wire logic [alias_smp_pkg::THR_W-1:0]   i_entry_threshold,
    input  wire logic [alias_smp_pkg::IDX_W-1:0]   i_entry_alias,
    input  wire logic [alias_smp_pkg::LCG_W-1:0]   i_seed_value,
    output logic                                   o_sample_valid,
    output logic [alias_smp_pkg::IDX_W-1:0]        o_sample_index,
    output logic                                   o_from_alias
);

    localparam int ENT_W  = alias_smp_pkg::THR_W + alias_smp_pkg::IDX_W;
    localparam int PROD_W = alias_smp_pkg::DRAW_W + alias_smp_pkg::SIZE_W;
    localparam int LCG_W  = alias_smp_pkg::LCG_W;
    localparam int HALF_W = alias_smp_pkg::HALF_W;
    localparam int DRAW_W = alias_smp_pkg::DRAW_W;
    localparam int IDX_W  = alias_smp_pkg::IDX_W;
    localparam int THR_W  = alias_smp_pkg::THR_W;
    localparam int SIZE_W = alias_smp_pkg::SIZE_W;

    logic [LCG_W-1:0]                  r_lcg;
    logic [LCG_W-1:0]                  n_lcg;
    logic [LCG_W-1:0]                  r_p_lo;
    logic [HALF_W-1:0]                 r_p_hi;
    logic [HALF_W-1:0]                 mul_a;
    logic [alias_smp_pkg::MUL_W-1:0]   mul_p;
    logic [15:0]                       s_times5;
    logic [SIZE_W-1:0]                 eff_size;
    logic [PROD_W-1:0]                 slot_prod;
    logic [IDX_W-1:0]                  r_slot;
    logic [ENT_W-1:0]                  mem [0:alias_smp_pkg::MAX_CATEGORIES-1];
    logic [ENT_W-1:0]                  r_rd_data;
    logic [THR_W-1:0]                  rd_thr;
    logic [IDX_W-1:0]                  rd_alias;
    logic                              keep;
    logic                              r_out_valid;
    logic [IDX_W-1:0]                  r_out_index;
    logic                              r_out_alias;

    // shared 24x32 multiplier, low half then high half of the state
    assign mul_a = i_cmd.mul_hi ? r_lcg[LCG_W-1:HALF_W] : r_lcg[HALF_W-1:0];
    assign mul_p = mul_a * alias_smp_pkg::LCG_MULT_LO;

    // multiplier bits above 32 are 5: only 16 bits survive the shift by 32
    assign s_times5 = {r_lcg[13:0], 2'b00} + r_lcg[15:0];

    always_comb begin
        n_lcg = r_p_lo + {r_p_hi, {HALF_W{1'b0}}} + {s_times5, {DRAW_W{1'b0}}}
              + alias_smp_pkg::LCG_INC;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_p_lo <= mul_p[LCG_W-1:0];
        end
        if (i_cmd.mul_hi) begin
            r_p_hi <= mul_p[HALF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg <= alias_smp_pkg::LCG_RESET;
        end else if (i_cmd.load_seed) begin
            r_lcg <= i_seed_value;
        end else if (i_cmd.add_step) begin
            r_lcg <= n_lcg;
        end
    end

    // size zero acts as one, oversize saturates
    always_comb begin
        if (i_table_size == '0) begin
            eff_size = SIZE_W'(1);
        end else if (i_table_size > SIZE_W'(alias_smp_pkg::MAX_CATEGORIES)) begin
            eff_size = SIZE_W'(alias_smp_pkg::MAX_CATEGORIES);
        end else begin
            eff_size = i_table_size;
        end
    end

    assign slot_prod = r_lcg[LCG_W-1:LCG_W-DRAW_W] * eff_size;

    always_ff @(posedge i_clk) begin
        if (i_cmd.slot_en) begin
            r_slot <= slot_prod[DRAW_W+IDX_W-1:DRAW_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry) begin
            mem[i_entry_index] <= {i_entry_threshold, i_entry_alias};
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= mem[r_slot];
        end
    end

    assign rd_thr   = r_rd_data[ENT_W-1:IDX_W];
    assign rd_alias = r_rd_data[IDX_W-1:0];
    assign keep     = {1'b0, r_lcg[LCG_W-1:LCG_W-DRAW_W]} < rd_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.decide;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_out_index <= keep ? r_slot : rd_alias;
            r_out_alias <= !keep;
        end
    end

    assign o_sample_valid = r_out_valid;
    assign o_sample_index = r_out_index;
    assign o_from_alias   = r_out_alias;

endmodule

`default_nettype wire
